/* rtl/core/mhpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue package
// Shared types and codes for the heap sequencer, its storage and the top level.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Width of the fixed fields of a request and a result.
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 8;

    // Operation carried by a request.
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // Outcome reported with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_READ,
        S_UP_CMP,
        S_RM_LOAD,
        S_DN_READ,
        S_DN_CMP,
        S_DONE
    } t_state;

    // One result as it leaves the sequencer.
    typedef struct packed {
        logic signed [KEY_W-1:0] removed_value;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      count;
    } t_rsp;

endpackage

/* rtl/core/mhpq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue channels
// Valid/ready channels for requests into the queue and results out of it.
// ----------------------------------------------------------------------------

// Request channel: an insert of a key or a remove of the maximum.
interface mhpq_req_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic signed [31:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Result channel: one result for every request.
interface mhpq_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  removed_value;
    logic [1:0]          status;
    logic [7:0]          count;

    modport source (output valid, output removed_value, output status, output count,
                    input ready);
    modport sink   (input valid, input removed_value, input status, input count,
                    output ready);
endinterface

/* rtl/core/mhpq_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap storage
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mhpq_store #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr_a,
    input  logic [AW-1:0]                     i_raddr_b,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_rdata_a,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_rdata_b
);
    import mhpq_pkg::*;

    logic signed [KEY_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* rtl/core/mhpq_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sequencer
// Runs one insert or remove at a time, walking the heap through the storage
// with a moving hole: the travelling key stays in a register and is written
// once, where the walk stops.
// ----------------------------------------------------------------------------
module mhpq_seq #(
    parameter int unsigned CAPACITY = 128,
    parameter int unsigned AW       = 7,
    parameter int unsigned CW       = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request side
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic                              i_cmd,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_value,
    // Result side
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output mhpq_pkg::t_rsp                    o_res,
    // Storage ports
    output logic                              o_we,
    output logic [AW-1:0]                     o_waddr,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_wdata,
    output logic [AW-1:0]                     o_raddr_a,
    output logic [AW-1:0]                     o_raddr_b,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_rdata_a,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_rdata_b
);
    import mhpq_pkg::*;

    // Child positions need one more bit than a position; compares use two more.
    localparam int unsigned XW = AW + 2;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_pos, n_pos;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_removed, n_removed;
    t_status                 r_status, n_status;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic [AW-1:0]           w_parent;
    logic [AW:0]             w_left;
    logic [AW:0]             w_right;
    logic                    w_has_left;
    logic                    w_has_right;
    logic                    w_pick_right;
    logic signed [KEY_W-1:0] w_child_val;
    logic [AW-1:0]           w_child_pos;
    logic                    w_up_move;
    logic                    w_dn_move;
    logic [CW+COUNT_W-1:0]   w_count_ext;

    // Heap geometry around the current position.
    assign w_accept     = i_req_valid && o_req_ready;
    assign w_full       = (XW'(r_count) >= XW'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_parent     = AW'((r_pos - AW'(1)) >> 1);
    assign w_left       = {r_pos, 1'b1};
    assign w_right      = w_left + (AW+1)'(1);
    assign w_has_left   = (XW'(w_left) < XW'(r_count));
    assign w_has_right  = (XW'(w_right) < XW'(r_count));

    // Larger child, the left one on a tie, and whether the hole moves.
    assign w_pick_right = w_has_right && (i_rdata_b > i_rdata_a);
    assign w_child_val  = w_pick_right ? i_rdata_b : i_rdata_a;
    assign w_child_pos  = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_up_move    = (r_key > i_rdata_a);
    assign w_dn_move    = (w_child_val > r_key);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_REMOVE) begin
                        n_state = w_empty ? S_DONE : S_RM_LOAD;
                    end else begin
                        n_state = w_full ? S_DONE : S_UP_READ;
                    end
                end
            end
            S_UP_READ: begin
                n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = w_up_move ? S_UP_READ : S_DONE;
            end
            S_RM_LOAD: begin
                n_state = w_empty ? S_DONE : S_DN_READ;
            end
            S_DN_READ: begin
                n_state = w_has_left ? S_DN_CMP : S_DONE;
            end
            S_DN_CMP: begin
                n_state = w_dn_move ? S_DN_READ : S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Storage accesses and datapath register updates.
    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_removed = r_removed;
        n_status  = r_status;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = r_key;
        o_raddr_a = '0;
        o_raddr_b = '0;
        case (r_state)
            S_IDLE: begin
                n_removed = '0;
                n_status  = ST_DONE;
                if (w_accept) begin
                    if (i_cmd == CMD_REMOVE) begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // Fetch the root and the last entry together.
                            o_raddr_b = AW'(r_count - CW'(1));
                            n_count   = r_count - CW'(1);
                            n_pos     = '0;
                        end
                    end else begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_key   = i_value;
                            n_pos   = AW'(r_count);
                            n_count = r_count + CW'(1);
                        end
                    end
                end
            end
            S_UP_READ: begin
                if (r_pos == '0) begin
                    o_we = 1'b1;
                end else begin
                    o_raddr_a = w_parent;
                end
            end
            S_UP_CMP: begin
                // Pull the smaller parent down into the hole, or settle the key.
                o_we = 1'b1;
                if (w_up_move) begin
                    o_wdata = i_rdata_a;
                    n_pos   = w_parent;
                end
            end
            S_RM_LOAD: begin
                n_removed = i_rdata_a;
                n_key     = i_rdata_b;
            end
            S_DN_READ: begin
                if (w_has_left) begin
                    o_raddr_a = w_left[AW-1:0];
                    o_raddr_b = w_right[AW-1:0];
                end else begin
                    o_we = 1'b1;
                end
            end
            S_DN_CMP: begin
                // Lift the larger child into the hole, or settle the key.
                o_we = 1'b1;
                if (w_dn_move) begin
                    o_wdata = w_child_val;
                    n_pos   = w_child_pos;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    // Result, with the count reduced to the result field width.
    assign w_count_ext         = {{COUNT_W{1'b0}}, r_count};
    assign o_req_ready         = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.removed_value = r_removed;
    assign o_res.status        = r_status;
    assign o_res.count         = w_count_ext[COUNT_W-1:0];

endmodule

/* rtl/core/max_heap_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue
// A binary max-heap of up to CAPACITY signed 32-bit keys kept in one on-chip
// memory. Every request yields one result with a status and the new entry
// count; a remove also returns the largest key. One request is worked at a
// time. At each level of its walk the key takes one memory read and then one
// compare and write back. A finished result waits in an output register, so
// the next request is taken while the previous result is still waiting to be
// read.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);
    import mhpq_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic signed [KEY_W-1:0] w_wdata;
    logic [AW-1:0]           w_raddr_a;
    logic [AW-1:0]           w_raddr_b;
    logic signed [KEY_W-1:0] w_rdata_a;
    logic signed [KEY_W-1:0] w_rdata_b;
    logic                    w_res_valid;
    logic                    w_res_ready;
    t_rsp                    w_res;

    logic                    r_out_valid;
    t_rsp                    r_out;

    // Heap storage.
    mhpq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Insert and remove sequencer.
    mhpq_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_cmd       (i_req.cmd),
        .i_value     (i_req.value),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr_a   (w_raddr_a),
        .o_raddr_b   (w_raddr_b),
        .i_rdata_a   (w_rdata_a),
        .i_rdata_b   (w_rdata_b)
    );

    // Output register: takes a new result whenever it is empty or being drained.
    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.removed_value = r_out.removed_value;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.count         = r_out.count;

endmodule

/* rtl/core/mhpq_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Port-level checks on the results of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_chk #(
    parameter int unsigned CAPACITY = 128
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic signed [31:0] i_rsp_removed_value,
    input logic [1:0]         i_rsp_status,
    input logic [7:0]         i_rsp_count
);
    import mhpq_pkg::*;

    // A stalled result keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_removed_value)
            && $stable(i_rsp_status) && $stable(i_rsp_count))
        else $error("result changed while stalled");

    // Only the three defined outcomes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_DONE) || (i_rsp_status == ST_FULL)
            || (i_rsp_status == ST_EMPTY))
        else $error("undefined status code");

    // A rejected insert happens only at full capacity and returns no key.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_FULL)
            |-> (i_rsp_count == 8'(CAPACITY)) && (i_rsp_removed_value == '0))
        else $error("inconsistent full result");

    // A rejected remove reports an empty heap and returns no key.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_EMPTY)
            |-> (i_rsp_count == '0) && (i_rsp_removed_value == '0))
        else $error("inconsistent empty result");

endmodule

bind max_heap_priority_queue mhpq_chk #(
    .CAPACITY (CAPACITY)
) u_mhpq_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_removed_value (o_rsp.removed_value),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_count         (o_rsp.count)
);

/* tb/mhpq_heap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue checker
// Watches the request and result channels of the queue. It keeps its own
// heap, works out the result of every accepted request and compares each
// accepted result, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module mhpq_heap_checker #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mhpq_req_if  req,
    mhpq_rsp_if  rsp,
    output int   o_err_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen,
    output int   o_empty_seen
);
    import mhpq_pkg::*;

    // Shadow heap and its fill level.
    logic signed [KEY_W-1:0] key_store [CAPACITY];
    int unsigned             held = 0;

    // Results still owed by the queue, oldest first.
    t_rsp owed_q[$];

    int err_count  = 0;
    int checked    = 0;
    int full_seen  = 0;
    int empty_seen = 0;
    int owed       = 0;

    assign o_err_count  = err_count;
    assign o_pending    = owed;
    assign o_checked    = checked;
    assign o_full_seen  = full_seen;
    assign o_empty_seen = empty_seen;

    function automatic void swap_keys(input int unsigned a, input int unsigned b);
        logic signed [KEY_W-1:0] tmp;
        tmp          = key_store[a];
        key_store[a] = key_store[b];
        key_store[b] = tmp;
    endfunction

    // Apply one request to the shadow heap and return the result it must give.
    function automatic t_rsp heap_apply(input t_cmd op, input logic signed [KEY_W-1:0] key);
        t_rsp        r;
        int unsigned pos;
        int unsigned parent;
        int unsigned left;
        int unsigned right;
        int unsigned best;
        bit          moving;
        r.removed_value = '0;
        r.status        = ST_DONE;
        if (op == CMD_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // Append the key and walk it up while it beats its parent.
                pos            = held;
                key_store[pos] = key;
                held++;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (key_store[pos] > key_store[parent]) begin
                        swap_keys(pos, parent);
                        pos = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_value = key_store[0];
                held--;
                // Move the last key to the root and walk it down; ties go left.
                if (held > 0) begin
                    key_store[0] = key_store[held];
                    pos          = 0;
                    moving       = 1'b1;
                    while (moving) begin
                        left  = 2 * pos + 1;
                        right = left + 1;
                        best  = pos;
                        if (left < held && key_store[left] > key_store[best]) best = left;
                        if (right < held && key_store[right] > key_store[best]) best = right;
                        if (best == pos) begin
                            moving = 1'b0;
                        end else begin
                            swap_keys(pos, best);
                            pos = best;
                        end
                    end
                end
            end
        end
        r.count = COUNT_W'(held);
        return r;
    endfunction

    task automatic report_diff(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                 $time, field, want, got);
        err_count++;
    endtask

    // Sample both channels at the clock edge: results first, then requests.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            held = 0;
            owed_q.delete();
        end else begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                if (owed_q.size() == 0) begin
                    $display("%0t ns: result with no request outstanding, actual 0x%08h/%0d/%0d",
                             $time, rsp.removed_value, rsp.status, rsp.count);
                    err_count++;
                end else begin
                    want = owed_q.pop_front();
                    checked++;
                    if (want.status == ST_FULL) full_seen++;
                    if (want.status == ST_EMPTY) empty_seen++;
                    if (rsp.removed_value !== want.removed_value)
                        report_diff("removed_value", want.removed_value, rsp.removed_value);
                    if (rsp.status !== want.status)
                        report_diff("status", 32'(want.status), 32'(rsp.status));
                    if (rsp.count !== want.count)
                        report_diff("count", 32'(want.count), 32'(rsp.count));
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                owed_q.push_back(heap_apply(t_cmd'(req.cmd), req.value));
        end
        owed = owed_q.size();
    end

endmodule

/* tb/max_heap_priority_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives inserts and removes into the queue: a directed opening on the
// extreme keys, equal keys and removes from an empty heap, then random phases
// that fill the heap past full, drain it past empty and mix the two. Both
// channels idle at random, and the result side once holds off long enough to
// stall the request side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;
    import mhpq_pkg::*;

    localparam int unsigned CAPACITY     = 128;
    localparam int          RANDOM_ITEMS = 1580;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          CALM_FROM    = 700;
    localparam int          CALM_TO      = 1000;

    // Balance of operations within one random phase.
    typedef enum int {
        MIX_OPS,
        FILL_OPS,
        DRAIN_OPS
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    mhpq_req_if req_ch ();
    mhpq_rsp_if rsp_ch ();

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    int err_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;

    mhpq_heap_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen),
        .o_empty_seen(empty_seen)
    );

    bit calm      = 1'b0;
    int n_inserts = 0;
    int n_removes = 0;
    int cycles    = 0;
    int n_taken   = 0;
    int hold_left = 0;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("max_heap_priority_queue_tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, none while calm.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            n_taken++;
            if (n_taken == HOLD_AT) hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // Keys: mostly full range, with clusters of equal keys and the extremes.
    function automatic logic signed [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) return $urandom;
        if (sel < 80) return 32'(int'($urandom_range(8)) - 4);
        if (sel < 90) begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0;
                default: return -32'sd1;
            endcase
        end
        // Around the positive limit, wrapping into the most negative keys.
        return 32'h7fff_fff0 + $urandom_range(31);
    endfunction

    // Offer one request and return at the edge where it is accepted.
    task automatic offer(input t_cmd op, input logic signed [31:0] key);
        while (!calm && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.value <= key;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        if (op == CMD_INSERT) n_inserts++;
        else n_removes++;
    endtask

    initial begin
        t_phase phase;
        int     phase_left;
        int     phase_idx;
        int     n_random;
        t_cmd   op;
        int     sel;

        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd   <= CMD_INSERT;
        req_ch.value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: remove from empty, removal of the last entry, extremes,
        // equal keys, alternating bit patterns, then drain past empty.
        offer(CMD_REMOVE, $urandom);
        offer(CMD_INSERT, 32'sh7fff_ffff);
        offer(CMD_REMOVE, $urandom);
        offer(CMD_REMOVE, $urandom);
        offer(CMD_INSERT, 32'sh8000_0000);
        offer(CMD_INSERT, 32'sh0);
        offer(CMD_INSERT, -32'sd1);
        offer(CMD_INSERT, 32'sh7fff_ffff);
        repeat (3) offer(CMD_INSERT, 32'sd5);
        offer(CMD_INSERT, 32'sh8000_0000);
        offer(CMD_INSERT, 32'sh5555_5555);
        offer(CMD_INSERT, 32'shaaaa_aaaa);
        repeat (11) offer(CMD_REMOVE, $urandom);

        // Random phases: fill past full, mix, drain past empty, mix again.
        n_random  = 0;
        phase_idx = 0;
        while (n_random < RANDOM_ITEMS) begin
            case (phase_idx % 4)
                0:       phase = FILL_OPS;
                2:       phase = DRAIN_OPS;
                default: phase = MIX_OPS;
            endcase
            phase_idx++;
            phase_left = $urandom_range(240, 120);
            while (phase_left > 0 && n_random < RANDOM_ITEMS) begin
                calm = (n_random >= CALM_FROM && n_random < CALM_TO);
                sel  = $urandom_range(99);
                case (phase)
                    FILL_OPS:  op = (sel < 88) ? CMD_INSERT : CMD_REMOVE;
                    DRAIN_OPS: op = (sel < 88) ? CMD_REMOVE : CMD_INSERT;
                    default:   op = (sel < 50) ? CMD_INSERT : CMD_REMOVE;
                endcase
                offer(op, pick_key());
                phase_left--;
                n_random++;
            end
        end
        req_ch.valid <= 1'b0;
        calm = 1'b0;

        // Let every owed result arrive, then watch a little longer.
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d inserts and %0d removes, %0d results compared,",
                 n_inserts, n_removes, checked);
        $display("including %0d inserts into a full heap and %0d removes from an empty one.",
                 full_seen, empty_seen);
        if (err_count == 0 && pending == 0) begin
            $display("max_heap_priority_queue_tb: clean");
        end else begin
            $display("max_heap_priority_queue_tb: errors");
        end
        $finish;
    end

endmodule
